// ===== hw/rtl/xtt_pkg.sv =====
package xtt_pkg;

    // Default width of the saturating name and attribute counters.
    localparam int LENGTH_BITS_DEFAULT = 16;

    // Configuration port geometry: 32-bit data, word-aligned registers.
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    // Register index, taken from the word address bit.
    localparam logic REG_DOT_IS_SEPARATOR = 1'b0;

    // Role codes reported with every byte.
    localparam logic [2:0] ROLE_OUT   = 3'd0;
    localparam logic [2:0] ROLE_OPEN  = 3'd1;
    localparam logic [2:0] ROLE_SEP   = 3'd2;
    localparam logic [2:0] ROLE_NAME  = 3'd3;
    localparam logic [2:0] ROLE_ATTR  = 3'd4;
    localparam logic [2:0] ROLE_CLOSE = 3'd5;

    // Characters the lexer reacts to.
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

endpackage

// ===== hw/rtl/xml_tag_tokenizer.sv =====
// Byte-serial XML tag lexer. Every transfer on the data channel carries one
// document byte and yields exactly one result transfer that echoes the byte
// and gives its role (outside tag, opener, separator, name, attribute or
// closer), whether it lies inside a quoted value, end-of-tag flags for
// closing and self-closing tags, and saturating name and attribute lengths.
// The block takes one byte per clock: the tag state and the result register
// are both updated in the cycle a byte is accepted, so the next byte may
// follow immediately, and a held result stalls the input only while the
// result channel is stalled. A byte's result shows in the next cycle.
// The period-as-whitespace option is set through the configuration port at
// word address 0 (bit 0, reset 1) and should only be changed while idle.
module xml_tag_tokenizer #(
    parameter int LENGTH_BITS = xtt_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [xtt_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [xtt_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [xtt_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    // Byte input channel
    input  logic                                data_valid,
    output logic                                data_ready,
    input  logic [7:0]                          data_byte,
    // Result channel
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [7:0]                          byte_out,
    output logic [2:0]                          byte_role,
    output logic                                quoted,
    output logic                                tag_end,
    output logic                                closing_tag,
    output logic                                self_closing,
    output logic [LENGTH_BITS-1:0]              name_length,
    output logic [LENGTH_BITS-1:0]              attr_length
);
    import xtt_pkg::*;

    typedef enum logic [2:0] {
        PH_OUTSIDE,
        PH_PRE_NAME,
        PH_AFTER_SLASH,
        PH_NAME,
        PH_POST_NAME,
        PH_ATTR
    } phase_t;

    logic                   dot_sep_reg;
    phase_t                 phase_reg, phase_next;
    logic                   sq_reg, sq_next;
    logic                   dq_reg, dq_next;
    logic                   closing_seen_reg, closing_seen_next;
    logic                   slash_seen_reg, slash_seen_next;
    logic [LENGTH_BITS-1:0] name_count_reg, name_count_next;
    logic [LENGTH_BITS-1:0] attr_count_reg, attr_count_next;

    logic                   result_valid_reg;
    logic [7:0]             byte_reg;
    logic [2:0]             role_reg, role_next;
    logic                   quoted_reg, quoted_next;
    logic                   tag_end_reg, tag_end_next;
    logic                   closing_reg, self_closing_reg;
    logic [LENGTH_BITS-1:0] name_len_reg, attr_len_reg;

    logic                   cfg_write;
    logic                   accept;
    logic                   is_space;
    logic                   quote_open;
    logic                   attr_step;
    logic [LENGTH_BITS-1:0] name_inc, attr_inc;

    // Configuration access: always ready, one register at word 0.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_DOT_IS_SEPARATOR)
                       ? {{(APB_DATA_BITS-1){1'b0}}, dot_sep_reg}
                       : '0;

    // The result register frees up when it is empty or being taken.
    assign data_ready = !result_valid_reg || result_ready;
    assign accept     = data_valid && data_ready;

    // Byte classes and saturating increments.
    assign is_space = (data_byte == CH_SPACE) || (data_byte == CH_TAB)
                      || (data_byte == CH_LF) || ((data_byte == CH_DOT) && dot_sep_reg);
    assign quote_open = sq_reg || dq_reg;
    assign name_inc = (&name_count_reg) ? name_count_reg : name_count_reg + 1'b1;
    assign attr_inc = (&attr_count_reg) ? attr_count_reg : attr_count_reg + 1'b1;

    // Tag state update and result for the incoming byte.
    always_comb
    begin
        phase_next        = phase_reg;
        sq_next           = sq_reg;
        dq_next           = dq_reg;
        closing_seen_next = closing_seen_reg;
        slash_seen_next   = slash_seen_reg;
        name_count_next   = name_count_reg;
        attr_count_next   = attr_count_reg;
        role_next         = ROLE_OUT;
        quoted_next       = 1'b0;
        tag_end_next      = 1'b0;
        attr_step         = 1'b0;

        if (phase_reg == PH_OUTSIDE) begin
            if (data_byte == CH_LT) begin
                role_next         = ROLE_OPEN;
                phase_next        = PH_PRE_NAME;
                sq_next           = 1'b0;
                dq_next           = 1'b0;
                closing_seen_next = 1'b0;
                slash_seen_next   = 1'b0;
                name_count_next   = '0;
                attr_count_next   = '0;
            end
        end else if (data_byte == CH_GT && !(phase_reg == PH_ATTR && quote_open)) begin
            role_next    = ROLE_CLOSE;
            tag_end_next = 1'b1;
        end else begin
            case (phase_reg)
                PH_PRE_NAME, PH_AFTER_SLASH:
                begin
                    if (is_space) begin
                        role_next = ROLE_SEP;
                    end else if (phase_reg == PH_PRE_NAME && data_byte == CH_SLASH) begin
                        role_next         = ROLE_SEP;
                        closing_seen_next = 1'b1;
                        phase_next        = PH_AFTER_SLASH;
                    end else begin
                        role_next       = ROLE_NAME;
                        name_count_next = name_inc;
                        phase_next      = PH_NAME;
                    end
                end
                PH_NAME, PH_POST_NAME:
                begin
                    if (data_byte == CH_SLASH) begin
                        role_next       = ROLE_SEP;
                        slash_seen_next = 1'b1;
                        phase_next      = PH_POST_NAME;
                    end else if (is_space) begin
                        role_next  = ROLE_SEP;
                        phase_next = PH_POST_NAME;
                    end else if (phase_reg == PH_NAME) begin
                        role_next       = ROLE_NAME;
                        name_count_next = name_inc;
                    end else begin
                        role_next  = ROLE_ATTR;
                        attr_step  = 1'b1;
                        phase_next = PH_ATTR;
                    end
                end
                default:
                begin
                    role_next = ROLE_ATTR;
                    attr_step = 1'b1;
                end
            endcase
        end

        // Attribute text: count it and track quotes, including the first byte.
        if (attr_step) begin
            attr_count_next = attr_inc;
            if (sq_reg) begin
                if (data_byte == CH_SQUOTE) sq_next = 1'b0;
                else                        quoted_next = 1'b1;
            end else if (dq_reg) begin
                if (data_byte == CH_DQUOTE) dq_next = 1'b0;
                else                        quoted_next = 1'b1;
            end else if (data_byte == CH_SQUOTE) begin
                sq_next = 1'b1;
            end else if (data_byte == CH_DQUOTE) begin
                dq_next = 1'b1;
            end else if (data_byte == CH_SLASH) begin
                slash_seen_next = 1'b1;
            end
        end
    end

    // Configuration, tag state and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dot_sep_reg      <= 1'b1;
            phase_reg        <= PH_OUTSIDE;
            sq_reg           <= 1'b0;
            dq_reg           <= 1'b0;
            closing_seen_reg <= 1'b0;
            slash_seen_reg   <= 1'b0;
            name_count_reg   <= '0;
            attr_count_reg   <= '0;
            result_valid_reg <= 1'b0;
            byte_reg         <= '0;
            role_reg         <= ROLE_OUT;
            quoted_reg       <= 1'b0;
            tag_end_reg      <= 1'b0;
            closing_reg      <= 1'b0;
            self_closing_reg <= 1'b0;
            name_len_reg     <= '0;
            attr_len_reg     <= '0;
        end else begin
            if (cfg_write && paddr[2] == REG_DOT_IS_SEPARATOR) begin
                dot_sep_reg <= pwdata[0];
            end

            if (accept) begin
                result_valid_reg <= 1'b1;
                byte_reg         <= data_byte;
                role_reg         <= role_next;
                quoted_reg       <= quoted_next;
                tag_end_reg      <= tag_end_next;
                closing_reg      <= tag_end_next && closing_seen_next;
                self_closing_reg <= tag_end_next && slash_seen_next;
                name_len_reg     <= (phase_next == PH_OUTSIDE) ? '0 : name_count_next;
                attr_len_reg     <= (phase_next == PH_OUTSIDE) ? '0 : attr_count_next;

                // A tag closer clears the whole tag state.
                if (tag_end_next) begin
                    phase_reg        <= PH_OUTSIDE;
                    sq_reg           <= 1'b0;
                    dq_reg           <= 1'b0;
                    closing_seen_reg <= 1'b0;
                    slash_seen_reg   <= 1'b0;
                    name_count_reg   <= '0;
                    attr_count_reg   <= '0;
                end else begin
                    phase_reg        <= phase_next;
                    sq_reg           <= sq_next;
                    dq_reg           <= dq_next;
                    closing_seen_reg <= closing_seen_next;
                    slash_seen_reg   <= slash_seen_next;
                    name_count_reg   <= name_count_next;
                    attr_count_reg   <= attr_count_next;
                end
            end else if (result_ready) begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign byte_out     = byte_reg;
    assign byte_role    = role_reg;
    assign quoted       = quoted_reg;
    assign tag_end      = tag_end_reg;
    assign closing_tag  = closing_reg;
    assign self_closing = self_closing_reg;
    assign name_length  = name_len_reg;
    assign attr_length  = attr_len_reg;

    // A tag end is always reported with the closer role.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && tag_end_reg |-> role_reg == ROLE_CLOSE)
        else $error("tag end without closer role");

    // Closing and self-closing flags appear only on a tag end.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (closing_reg || self_closing_reg) |-> tag_end_reg)
        else $error("tag flag outside tag end");

    // Outside a tag, both quote flags and both counters are clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_OUTSIDE |-> !sq_reg && !dq_reg && name_count_reg == '0
                                    && attr_count_reg == '0)
        else $error("tag state not cleared outside tag");

    // Only one kind of quote can be open at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(sq_reg && dq_reg))
        else $error("both quote kinds open");

    // A quoted byte is always attribute text.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && quoted_reg |-> role_reg == ROLE_ATTR)
        else $error("quoted byte outside attribute text");

endmodule
